// ===== design/dtum_pkg.sv =====
// Shared types and constants for the device table upsert/merge block.
package dtum_pkg;

   localparam int unsigned KEY_W = 58;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_INVALID = 2'd1,
      STATUS_FULL    = 2'd2
   } status_type;

   typedef enum logic {
      REQ_UPSERT = 1'b0,
      REQ_CLEAR  = 1'b1
   } req_kind_type;

   // one table entry, key first
   typedef struct packed {
      logic [1:0]  radio;
      logic [7:0]  addr_kind;
      logic [47:0] address;
      logic [7:0]  signal;
      logic [7:0]  name_size;
      logic [23:0] dev_class;
      logic [15:0] appearance;
      logic [7:0]  maker_len;
      logic [7:0]  advert_len;
      logic [31:0] last_seen;
   } entry_type;

   // controller -> datapath
   typedef struct packed {
      logic load;       // capture request
      logic clear;      // zero the fill count
      logic rd;         // issue read at scan index
      logic scan_first; // reset scan index
      logic merge;      // write merged entry at hit slot
      logic append;     // write new entry at fill count
      logic fin_invalid;
      logic fin_full;
      logic fin_clear;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic is_clear;
      logic is_valid;
      logic scan_done;  // scan index reached fill count
      logic hit;        // registered read matched key
      logic full;
   } stat_type;

endpackage

// ===== design/dtum_ctrl.sv =====
// Sequencing state machine for the device table search and update.
module dtum_ctrl
   import dtum_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   input  logic     rsp_busy,
   input  stat_type stat,
   output cmd_type  cmd
);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_DECIDE= 6'b000010,
      ST_ISSUE = 6'b000100,
      ST_CHECK = 6'b001000,
      ST_WRITE = 6'b010000,
      ST_WAIT  = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic      hit_ff, hit_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      hit_in   = hit_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (!rsp_busy) begin
               priority if (stat.is_clear) begin
                  cmd.clear     = 1'b1;
                  cmd.fin_clear = 1'b1;
                  state_in      = ST_IDLE;
               end else if (!stat.is_valid) begin
                  cmd.fin_invalid = 1'b1;
                  state_in        = ST_IDLE;
               end else begin
                  cmd.scan_first = 1'b1;
                  state_in       = ST_ISSUE;
               end
            end
         end
         ST_ISSUE: begin
            if (stat.scan_done) begin
               hit_in   = 1'b0;
               state_in = ST_WAIT;
            end else begin
               cmd.rd   = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (stat.hit) begin
               hit_in   = 1'b1;
               state_in = ST_WAIT;
            end else begin
               state_in = ST_ISSUE;
            end
         end
         ST_WAIT: begin
            // hold until the output register is free
            if (!rsp_busy) begin
               priority if (hit_ff) begin
                  cmd.merge = 1'b1;
               end else if (stat.full) begin
                  cmd.fin_full = 1'b1;
               end else begin
                  cmd.append = 1'b1;
               end
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         hit_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         hit_ff   <= hit_in;
      end
   end

endmodule

// ===== design/dtum_datapath.sv =====
// Entry memory, key compare, merge logic and result register.
module dtum_datapath
   import dtum_pkg::*;
#(
   parameter int unsigned ENTRIES = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_type,
   input  logic        record_valid,
   input  logic [1:0]  radio_kind,
   input  logic [7:0]  address_type,
   input  logic [47:0] device_address,
   input  logic signed [7:0] signal_dbm,
   input  logic [7:0]  name_length,
   input  logic [23:0] device_class,
   input  logic [15:0] appearance_code,
   input  logic [7:0]  maker_data_length,
   input  logic [7:0]  advert_length,
   input  logic [31:0] now_ms,
   input  cmd_type     cmd,
   output stat_type    stat,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_busy,
   output logic [1:0]  rsp_status,
   output logic [5:0]  rsp_slot_index,
   output logic        rsp_inserted,
   output logic        rsp_record_changed,
   output logic        rsp_take_name,
   output logic        rsp_take_maker_data,
   output logic        rsp_take_advert,
   output logic [6:0]  rsp_entry_count
);

   localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int unsigned CW = $clog2(ENTRIES + 1);

   entry_type mem [ENTRIES];
   entry_type rd_ff;
   entry_type req_ff;
   logic      kind_ff, valid_ff;
   logic [CW-1:0] count_ff;
   logic [CW-1:0] idx_ff;
   logic [IW-1:0] slot_ff;

   logic        out_v_ff;
   logic [1:0]  st_ff;
   logic [5:0]  slot_out_ff;
   logic        ins_ff, chg_ff, tn_ff, tm_ff, ta_ff;
   logic [6:0]  cnt_out_ff;

   entry_type merged;
   logic      tn, tm, ta, chg;
   logic      wr;
   logic [IW-1:0] wr_addr;
   entry_type wr_data;
   logic [CW-1:0] count_next;

   assign stat.is_clear  = (kind_ff == REQ_CLEAR);
   assign stat.is_valid  = valid_ff;
   assign stat.scan_done = (idx_ff >= count_ff);
   assign stat.hit       = ({rd_ff.radio, rd_ff.addr_kind, rd_ff.address} ==
                            {req_ff.radio, req_ff.addr_kind, req_ff.address});
   assign stat.full      = (count_ff >= CW'(ENTRIES));

   always_comb begin
      merged = rd_ff;
      tn = 1'b0; tm = 1'b0; ta = 1'b0; chg = 1'b0;
      if ($signed(req_ff.signal) > $signed(rd_ff.signal)) merged.signal = req_ff.signal;
      if (req_ff.name_size > rd_ff.name_size) begin
         merged.name_size = req_ff.name_size; tn = 1'b1; chg = 1'b1;
      end
      if (req_ff.dev_class != '0 && rd_ff.dev_class == '0) begin
         merged.dev_class = req_ff.dev_class; chg = 1'b1;
      end
      if (req_ff.appearance != '0 && rd_ff.appearance == '0) begin
         merged.appearance = req_ff.appearance; chg = 1'b1;
      end
      if (req_ff.maker_len > rd_ff.maker_len) begin
         merged.maker_len = req_ff.maker_len; tm = 1'b1; chg = 1'b1;
      end
      if (req_ff.advert_len > rd_ff.advert_len) begin
         merged.advert_len = req_ff.advert_len; ta = 1'b1;
      end
      merged.last_seen = req_ff.last_seen;
   end

   assign wr      = cmd.merge || cmd.append;
   assign wr_addr = cmd.merge ? slot_ff : count_ff[IW-1:0];
   assign wr_data = cmd.merge ? merged : req_ff;
   assign count_next = cmd.clear ? '0 : (cmd.append ? count_ff + 1'b1 : count_ff);

   // entries past the fill count are never read, so the memory needs no clear
   always_ff @(posedge clock) begin
      if (wr) mem[wr_addr] <= wr_data;
      if (cmd.rd) begin
         rd_ff   <= mem[idx_ff[IW-1:0]];
         slot_ff <= idx_ff[IW-1:0];
      end
      if (cmd.load) begin
         kind_ff  <= req_type;
         valid_ff <= record_valid;
         req_ff   <= '{radio_kind, address_type, device_address, signal_dbm,
                       name_length, device_class, appearance_code,
                       maker_data_length, advert_length, now_ms};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         idx_ff   <= '0;
         out_v_ff <= 1'b0;
      end else begin
         count_ff <= count_next;
         if (cmd.scan_first) idx_ff <= '0;
         else if (cmd.rd)    idx_ff <= idx_ff + 1'b1;
         if (wr || cmd.fin_full || cmd.fin_invalid || cmd.fin_clear) out_v_ff <= 1'b1;
         else if (!rsp_stall) out_v_ff <= 1'b0;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (wr || cmd.fin_full || cmd.fin_invalid || cmd.fin_clear) begin
         st_ff       <= cmd.fin_full ? STATUS_FULL :
                        (cmd.fin_invalid ? STATUS_INVALID : STATUS_OK);
         slot_out_ff <= wr ? 6'(wr_addr) : 6'd0;
         ins_ff      <= cmd.append;
         chg_ff      <= cmd.append || (cmd.merge && chg);
         tn_ff       <= cmd.append || (cmd.merge && tn);
         tm_ff       <= cmd.append || (cmd.merge && tm);
         ta_ff       <= cmd.append || (cmd.merge && ta);
         cnt_out_ff  <= 7'(count_next);
      end
   end

   assign rsp_busy            = out_v_ff && rsp_stall;
   assign rsp_valid           = out_v_ff;
   assign rsp_status          = st_ff;
   assign rsp_slot_index      = slot_out_ff;
   assign rsp_inserted        = ins_ff;
   assign rsp_record_changed  = chg_ff;
   assign rsp_take_name       = tn_ff;
   assign rsp_take_maker_data = tm_ff;
   assign rsp_take_advert     = ta_ff;
   assign rsp_entry_count     = cnt_out_ff;

endmodule

// ===== design/device_table_upsert_merge.sv =====
// Top level of the device table upsert/merge block.
// Usage: a request (upsert a sighting or clear the table) enters on req_*
// when req_valid is high and req_stall is low; one response leaves on rsp_*
// per request when rsp_valid is high and rsp_stall is low.
// Search: an upsert scans the filled entries in order through the single
// read port of the entry memory, one read and one key check per entry; a
// hit ends the scan, and a miss reads all filled entries before it appends
// or reports a full table. A clear or invalid request does no scan.
// One request is in work at a time; req_stall is high until it is done.
// The response sits in an output register; while the receiver stalls it
// the next request is still taken, but it waits before its search until
// the register frees up.
// Reset empties the table at once (fill count to zero); no clearing pass.
module device_table_upsert_merge
   import dtum_pkg::*;
#(
   parameter int unsigned ENTRIES = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_type,
   input  logic        req_record_valid,
   input  logic [1:0]  req_radio_kind,
   input  logic [7:0]  req_address_type,
   input  logic [47:0] req_device_address,
   input  logic signed [7:0] req_signal_dbm,
   input  logic [7:0]  req_name_length,
   input  logic [23:0] req_device_class,
   input  logic [15:0] req_appearance_code,
   input  logic [7:0]  req_maker_data_length,
   input  logic [7:0]  req_advert_length,
   input  logic [31:0] req_now_ms,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [5:0]  rsp_slot_index,
   output logic        rsp_inserted,
   output logic        rsp_record_changed,
   output logic        rsp_take_name,
   output logic        rsp_take_maker_data,
   output logic        rsp_take_advert,
   output logic [6:0]  rsp_entry_count
);

   cmd_type  cmd;
   stat_type stat;
   logic     busy;

   dtum_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall,
      .rsp_busy(busy), .stat, .cmd
   );

   dtum_datapath #(.ENTRIES(ENTRIES)) u_dp (
      .clock, .reset,
      .req_type, .record_valid(req_record_valid), .radio_kind(req_radio_kind),
      .address_type(req_address_type), .device_address(req_device_address),
      .signal_dbm(req_signal_dbm), .name_length(req_name_length),
      .device_class(req_device_class), .appearance_code(req_appearance_code),
      .maker_data_length(req_maker_data_length), .advert_length(req_advert_length),
      .now_ms(req_now_ms), .cmd, .stat,
      .rsp_valid, .rsp_stall, .rsp_busy(busy), .rsp_status, .rsp_slot_index,
      .rsp_inserted, .rsp_record_changed, .rsp_take_name, .rsp_take_maker_data,
      .rsp_take_advert, .rsp_entry_count
   );

endmodule
